/* rtl/srs_pkg.sv */
// ============================================================================
// srs_pkg: shared types and constants of the shadow response shader
// Register indexes, fixed-point constants and the item and config structs.
// ============================================================================
package srs_pkg;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] REG_LIGHT_DIRECTION = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_NORMAL_BIAS     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_NORMAL_SCALE    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_FADE_START      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_FADE_SCALE      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_SHADOW_COLOR    = 3'd5;

   // Widest register sets the write data width.
   localparam int unsigned CSR_DATA_W = 48;

   // Fixed-point constants.
   localparam logic [15:0]        ONE_Q15            = 16'd32768;
   localparam logic signed [33:0] ONE_Q13_AT_Q28     = 34'sd268435456;
   localparam logic signed [23:0] NORMAL_SCALE_RESET = 24'sd65536;
   localparam logic signed [18:0] TINT_MAX           = 19'sd32767;
   localparam logic signed [18:0] TINT_MIN           = -19'sd32768;

   // Number of register stages in the shading pipeline.
   localparam int unsigned PIPE_DEPTH = 7;

   // Live configuration as seen by the datapath.
   typedef struct packed {
      logic signed [15:0] light_x;
      logic signed [15:0] light_y;
      logic signed [15:0] light_z;
      logic signed [23:0] normal_bias;
      logic signed [23:0] normal_scale;
      logic signed [31:0] fade_start;
      logic signed [31:0] fade_scale;
      logic signed [15:0] color_r;
      logic signed [15:0] color_g;
      logic signed [15:0] color_b;
   } cfg_type;

   // One pixel entering the shader.
   typedef struct packed {
      logic [15:0]        occlusion;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic [30:0]        view_distance;
   } req_item_type;

   // One shaded result.
   typedef struct packed {
      logic [15:0]        facing_term;
      logic [15:0]        shadow_strength;
      logic [15:0]        fade_factor;
      logic signed [15:0] tint_red;
      logic signed [15:0] tint_green;
      logic signed [15:0] tint_blue;
   } rsp_item_type;

endpackage

/* rtl/srs_if.sv */
// ============================================================================
// srs_if: channel interfaces of the shadow response shader
// Pixel request, shaded response and configuration write channels.
// ============================================================================

// Pixel request channel.
interface srs_req_if;
   logic               valid;
   logic               ready;
   logic [15:0]        occlusion;
   logic signed [15:0] normal_x;
   logic signed [15:0] normal_y;
   logic signed [15:0] normal_z;
   logic [30:0]        view_distance;

   modport source (output valid, output occlusion, output normal_x, output normal_y,
                   output normal_z, output view_distance, input ready);
   modport sink   (input valid, input occlusion, input normal_x, input normal_y,
                   input normal_z, input view_distance, output ready);
endinterface

// Shaded response channel.
interface srs_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        facing_term;
   logic [15:0]        shadow_strength;
   logic [15:0]        fade_factor;
   logic signed [15:0] tint_red;
   logic signed [15:0] tint_green;
   logic signed [15:0] tint_blue;

   modport source (output valid, output facing_term, output shadow_strength,
                   output fade_factor, output tint_red, output tint_green,
                   output tint_blue, input ready);
   modport sink   (input valid, input facing_term, input shadow_strength,
                   input fade_factor, input tint_red, input tint_green,
                   input tint_blue, output ready);
endinterface

// Configuration write channel.
interface srs_csr_if;
   logic                              valid;
   logic                              ready;
   logic [srs_pkg::CSR_INDEX_W-1:0]   index;
   logic [srs_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/srs_csr.sv */
// ============================================================================
// srs_csr: configuration registers
// Holds the six shading registers and presents them as one struct.
// ============================================================================
module srs_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            wr_valid,
   output logic                            wr_ready,
   input  logic [srs_pkg::CSR_INDEX_W-1:0] wr_index,
   input  logic [srs_pkg::CSR_DATA_W-1:0]  wr_data,
   output srs_pkg::cfg_type                cfg
);

   srs_pkg::cfg_type cfg_ff;
   srs_pkg::cfg_type cfg_in;

   // Writes are taken whenever reset is low; an unknown index leaves every
   // register alone.
   assign wr_ready = !reset;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_valid) begin
         case (wr_index)
            srs_pkg::REG_LIGHT_DIRECTION: begin
               cfg_in.light_x = $signed(wr_data[15:0]);
               cfg_in.light_y = $signed(wr_data[31:16]);
               cfg_in.light_z = $signed(wr_data[47:32]);
            end
            srs_pkg::REG_NORMAL_BIAS:  cfg_in.normal_bias  = $signed(wr_data[23:0]);
            srs_pkg::REG_NORMAL_SCALE: cfg_in.normal_scale = $signed(wr_data[23:0]);
            srs_pkg::REG_FADE_START:   cfg_in.fade_start   = $signed(wr_data[31:0]);
            srs_pkg::REG_FADE_SCALE:   cfg_in.fade_scale   = $signed(wr_data[31:0]);
            srs_pkg::REG_SHADOW_COLOR: begin
               cfg_in.color_r = $signed(wr_data[15:0]);
               cfg_in.color_g = $signed(wr_data[31:16]);
               cfg_in.color_b = $signed(wr_data[47:32]);
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff              <= '0;
         cfg_ff.normal_scale <= srs_pkg::NORMAL_SCALE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/srs_pipe.sv */
// ============================================================================
// srs_pipe: seven-stage shading datapath
// Dot product, normal term, fade, strength, weight and tint across the stages,
// with a valid bit per stage and a ready chain so bubbles collapse on stalls.
// ============================================================================
module srs_pipe (
   input  logic                  clock,
   input  logic                  reset,
   input  srs_pkg::cfg_type      cfg,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  srs_pkg::req_item_type in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output srs_pkg::rsp_item_type out_item
);

   localparam int unsigned DEPTH = srs_pkg::PIPE_DEPTH;

   // ------------------------------------------------------------------
   // Stage control
   // ------------------------------------------------------------------
   logic [DEPTH-1:0] vld_ff;
   logic [DEPTH-1:0] vld_in;
   logic [DEPTH-1:0] rdy;

   // A stage may load when it is empty or its successor loads this cycle.
   always_comb begin
      rdy[DEPTH-1] = !vld_ff[DEPTH-1] || out_ready;
      for (int i = DEPTH - 2; i >= 0; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
   end

   always_comb begin
      vld_in[0] = rdy[0] ? in_valid : vld_ff[0];
      for (int i = 1; i < DEPTH; i++) begin
         vld_in[i] = rdy[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // No item is taken while reset is high.
   assign in_ready  = rdy[0] && !reset;
   assign out_valid = vld_ff[DEPTH-1];

   // ------------------------------------------------------------------
   // Stage 1: light-normal products and distance difference
   // ------------------------------------------------------------------
   logic signed [31:0] px1_ff, py1_ff, pz1_ff;
   logic signed [32:0] diff1_ff;
   logic [15:0]        occ1_ff;

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         px1_ff   <= cfg.light_x * in_item.normal_x;
         py1_ff   <= cfg.light_y * in_item.normal_y;
         pz1_ff   <= cfg.light_z * in_item.normal_z;
         diff1_ff <= $signed({cfg.fade_start[31], cfg.fade_start})
                   - $signed({2'b00, in_item.view_distance});
         occ1_ff  <= in_item.occlusion;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: biased dot product and fade product
   // ------------------------------------------------------------------
   logic signed [34:0] biased_in, biased2_ff;
   logic signed [64:0] f2_ff;
   logic [15:0]        occ2_ff;

   always_comb begin
      biased_in = $signed({{3{px1_ff[31]}}, px1_ff})
                + $signed({{3{py1_ff[31]}}, py1_ff})
                + $signed({{3{pz1_ff[31]}}, pz1_ff})
                + $signed({cfg.normal_bias[23], cfg.normal_bias, 10'b0});
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         biased2_ff <= biased_in;
         f2_ff      <= diff1_ff * cfg.fade_scale;
         occ2_ff    <= occ1_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: scaled normal product and fade saturation
   // ------------------------------------------------------------------
   logic signed [58:0] p3_ff;
   logic [15:0]        fade_in, fade3_ff;
   logic [15:0]        occ3_ff;

   // Fade is Q.32: nonpositive gives zero, one or more gives one.
   always_comb begin
      if (f2_ff[64] || (f2_ff == '0)) begin
         fade_in = '0;
      end else if (|f2_ff[63:32]) begin
         fade_in = srs_pkg::ONE_Q15;
      end else begin
         fade_in = {1'b0, f2_ff[31:17]};
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         p3_ff    <= biased2_ff * cfg.normal_scale;
         fade3_ff <= fade_in;
         occ3_ff  <= occ2_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: normal term saturation and shadow strength
   // ------------------------------------------------------------------
   logic [15:0] nterm_in, nterm4_ff;
   logic [16:0] sum_in;
   logic [15:0] strength_in, strength4_ff;
   logic [15:0] fade4_ff;

   // Normal product is Q.42; the sum with occlusion clamps at one.
   always_comb begin
      if (p3_ff[58] || (p3_ff == '0)) begin
         nterm_in = '0;
      end else if (|p3_ff[57:42]) begin
         nterm_in = srs_pkg::ONE_Q15;
      end else begin
         nterm_in = {1'b0, p3_ff[41:27]};
      end
      sum_in = {1'b0, occ3_ff} + {1'b0, nterm_in};
      if (sum_in > {1'b0, srs_pkg::ONE_Q15}) begin
         strength_in = srs_pkg::ONE_Q15;
      end else begin
         strength_in = sum_in[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         nterm4_ff    <= nterm_in;
         strength4_ff <= strength_in;
         fade4_ff     <= fade3_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: combined shadow weight k = strength * fade in Q1.15
   // ------------------------------------------------------------------
   logic [31:0] sf_prod;
   logic [15:0] k5_ff;
   logic [15:0] nterm5_ff, strength5_ff, fade5_ff;

   assign sf_prod = strength4_ff * fade4_ff;

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         k5_ff        <= sf_prod[30:15];
         nterm5_ff    <= nterm4_ff;
         strength5_ff <= strength4_ff;
         fade5_ff     <= fade4_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 6: weight times each shadow color channel
   // ------------------------------------------------------------------
   logic signed [16:0] k_s;
   logic signed [32:0] kr6_ff, kg6_ff, kb6_ff;
   logic [15:0]        nterm6_ff, strength6_ff, fade6_ff;

   assign k_s = $signed({1'b0, k5_ff});

   always_ff @(posedge clock) begin
      if (rdy[5]) begin
         kr6_ff       <= k_s * cfg.color_r;
         kg6_ff       <= k_s * cfg.color_g;
         kb6_ff       <= k_s * cfg.color_b;
         nterm6_ff    <= nterm5_ff;
         strength6_ff <= strength5_ff;
         fade6_ff     <= fade5_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 7: one minus product, floor to Q2.13, saturate; output register
   // ------------------------------------------------------------------
   function automatic logic signed [15:0] tint_of(input logic signed [32:0] kc);
      logic signed [33:0] v;
      logic signed [18:0] t;
      v = srs_pkg::ONE_Q13_AT_Q28 - $signed({kc[32], kc});
      t = v[33:15];
      if (t > srs_pkg::TINT_MAX) begin
         tint_of = 16'sd32767;
      end else if (t < srs_pkg::TINT_MIN) begin
         tint_of = -16'sd32768;
      end else begin
         tint_of = t[15:0];
      end
   endfunction

   srs_pkg::rsp_item_type out_ff;

   always_ff @(posedge clock) begin
      if (rdy[6]) begin
         out_ff.facing_term     <= nterm6_ff;
         out_ff.shadow_strength <= strength6_ff;
         out_ff.fade_factor     <= fade6_ff;
         out_ff.tint_red        <= tint_of(kr6_ff);
         out_ff.tint_green      <= tint_of(kg6_ff);
         out_ff.tint_blue       <= tint_of(kb6_ff);
      end
   end

   assign out_item = out_ff;

endmodule

/* rtl/shadow_response_shader.sv */
// ============================================================================
// shadow_response_shader: per-pixel shadow shading
// Normal term, shadow strength, distance fade and tinted color per pixel.
// ============================================================================
//
//   Channel   Dir   Handshake      Carries
//   req_if    in    valid/ready    occlusion, normal x/y/z, view distance
//   rsp_if    out   valid/ready    normal term, strength, fade, tint r/g/b
//   csr_if    in    valid/ready    register index, write data (ready out of reset)
//
// One item per clock sustained while the response side is ready; each item
// passes through the seven register stages of the shading pipeline.
// Every stage has its own valid bit and ready, so a stalled output holds its
// item while empty stages upstream keep filling; nothing is lost or repeated.
// Reset is synchronous: it empties the pipeline and restores the registers.
//
module shadow_response_shader (
   input  logic         clock,
   input  logic         reset,
   srs_req_if.sink      req_if,
   srs_rsp_if.source    rsp_if,
   srs_csr_if.sink      csr_if
);

   srs_pkg::cfg_type      cfg;
   srs_pkg::req_item_type in_item;
   srs_pkg::rsp_item_type out_item;

   // Configuration registers.
   srs_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_if.valid),
      .wr_ready (csr_if.ready),
      .wr_index (csr_if.index),
      .wr_data  (csr_if.data),
      .cfg      (cfg)
   );

   // Gather the request fields into one item.
   always_comb begin
      in_item.occlusion     = req_if.occlusion;
      in_item.normal_x      = req_if.normal_x;
      in_item.normal_y      = req_if.normal_y;
      in_item.normal_z      = req_if.normal_z;
      in_item.view_distance = req_if.view_distance;
   end

   // Shading pipeline.
   srs_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .in_item   (in_item),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_item  (out_item)
   );

   // Spread the result item onto the response channel.
   assign rsp_if.facing_term     = out_item.facing_term;
   assign rsp_if.shadow_strength = out_item.shadow_strength;
   assign rsp_if.fade_factor     = out_item.fade_factor;
   assign rsp_if.tint_red        = out_item.tint_red;
   assign rsp_if.tint_green      = out_item.tint_green;
   assign rsp_if.tint_blue       = out_item.tint_blue;

endmodule
